[src/time_of_day_clock_setter_assert.svh]
// Assertion macros used by the checker file.
`ifndef TIME_OF_DAY_CLOCK_SETTER_ASSERT_SVH
`define TIME_OF_DAY_CLOCK_SETTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TODS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tods assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TODS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tods assertion failed");

`endif

[src/tods_pkg.sv]
`timescale 1ns / 1ps
package tods_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_DIGIT = 2'd1,
      CMD_SET   = 2'd2,
      CMD_MODE  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      FIELD_RUN = 2'd0,
      FIELD_HOUR = 2'd1,
      FIELD_MIN = 2'd2,
      FIELD_SEC = 2'd3
   } edit_field_type;

   localparam logic [2:0] STATUS_CALC = 3'd4;
   localparam logic [4:0] HOUR_MAX    = 5'd23;
   localparam logic [5:0] MINSEC_MAX  = 6'd59;
   localparam logic [4:0] HOUR_RESET  = 5'd12;
   localparam logic [3:0] DIGIT_MAX   = 4'd9;

   localparam int RESULT_WIDTH = 20;
   localparam int RSP_DATA_WIDTH = 24;

   // hours in the lowest bits
   typedef struct packed {
      logic [2:0] status;
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
   } result_type;

endpackage

[src/tods_skid.sv]
`timescale 1ns / 1ps
module tods_skid #(
   parameter int DATA_WIDTH = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_data
);

   logic                  main_valid_ff, main_valid_in;
   logic [DATA_WIDTH-1:0] main_data_ff, main_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [DATA_WIDTH-1:0] skid_data_ff, skid_data_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

[src/time_of_day_clock_setter.sv]
// 24-hour hh:mm:ss clock driven by event beats (second tick, digit key, set key,
// mode key). Every accepted beat yields exactly one result beat carrying the
// time and status after that event. One beat per cycle is taken while the output
// stage's skid entry is empty: the next counter values are computed
// combinationally, and a two-entry output stage keeps the request side moving
// while a result waits. The result is registered in the output stage. After reset
// the clock reads 12:00:00, running.
`timescale 1ns / 1ps
module time_of_day_clock_setter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] digit, [7:4] zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [4:0] hours, [10:5] minutes, [16:11] seconds,
                                    // [19:17] status, [23:20] zero
);

   logic [4:0] hour_ff, hour_in;
   logic [5:0] minute_ff, minute_in;
   logic [5:0] second_ff, second_in;
   tods_pkg::edit_field_type edit_ff, edit_in;
   logic calc_ff, calc_in;

   logic                 req_fire;
   logic [3:0]           req_digit;
   tods_pkg::command_type req_cmd;
   logic [7:0]           hour_shift;
   logic [9:0]           minute_shift;
   logic [9:0]           second_shift;
   tods_pkg::result_type result;
   logic [tods_pkg::RESULT_WIDTH-1:0] rsp_result;

   assign req_fire  = req_tvalid && req_tready;
   assign req_digit = req_tdata[3:0];
   assign req_cmd   = tods_pkg::command_type'(req_tuser);

   // field * 10 + digit
   assign hour_shift   = {hour_ff, 3'b000} + {2'b00, hour_ff, 1'b0} + {4'b0000, req_digit};
   assign minute_shift = {1'b0, minute_ff, 3'b000} + {3'b000, minute_ff, 1'b0}
                         + {6'd0, req_digit};
   assign second_shift = {1'b0, second_ff, 3'b000} + {3'b000, second_ff, 1'b0}
                         + {6'd0, req_digit};

   always_comb begin
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      edit_in   = edit_ff;
      calc_in   = calc_ff;
      case (req_cmd)
         tods_pkg::CMD_TICK: begin
            if (calc_ff || edit_ff == tods_pkg::FIELD_RUN) begin
               if (second_ff >= tods_pkg::MINSEC_MAX) begin
                  second_in = 6'd0;
                  if (minute_ff >= tods_pkg::MINSEC_MAX) begin
                     minute_in = 6'd0;
                     hour_in   = (hour_ff >= tods_pkg::HOUR_MAX) ? 5'd0 : hour_ff + 5'd1;
                  end else begin
                     minute_in = minute_ff + 6'd1;
                  end
               end else begin
                  second_in = second_ff + 6'd1;
               end
            end
         end
         tods_pkg::CMD_DIGIT: begin
            if (!calc_ff && req_digit <= tods_pkg::DIGIT_MAX) begin
               case (edit_ff)
                  tods_pkg::FIELD_HOUR: begin
                     hour_in = (hour_shift > {3'b000, tods_pkg::HOUR_MAX})
                               ? {1'b0, req_digit} : hour_shift[4:0];
                  end
                  tods_pkg::FIELD_MIN: begin
                     minute_in = (minute_shift > {4'd0, tods_pkg::MINSEC_MAX})
                                 ? {2'b00, req_digit} : minute_shift[5:0];
                  end
                  tods_pkg::FIELD_SEC: begin
                     second_in = (second_shift > {4'd0, tods_pkg::MINSEC_MAX})
                                 ? {2'b00, req_digit} : second_shift[5:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         tods_pkg::CMD_SET: begin
            if (!calc_ff) begin
               case (edit_ff)
                  tods_pkg::FIELD_RUN:  edit_in = tods_pkg::FIELD_HOUR;
                  tods_pkg::FIELD_HOUR: edit_in = tods_pkg::FIELD_MIN;
                  tods_pkg::FIELD_MIN:  edit_in = tods_pkg::FIELD_SEC;
                  default:              edit_in = tods_pkg::FIELD_RUN;
               endcase
            end
         end
         default: begin
            calc_in = !calc_ff;
            edit_in = tods_pkg::FIELD_RUN;
         end
      endcase
   end

   always_comb begin
      result.hours   = hour_in;
      result.minutes = minute_in;
      result.seconds = second_in;
      result.status  = calc_in ? tods_pkg::STATUS_CALC : {1'b0, edit_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff   <= tods_pkg::HOUR_RESET;
         minute_ff <= 6'd0;
         second_ff <= 6'd0;
         edit_ff   <= tods_pkg::FIELD_RUN;
         calc_ff   <= 1'b0;
      end else if (req_fire) begin
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         edit_ff   <= edit_in;
         calc_ff   <= calc_in;
      end
   end

   tods_skid #(
      .DATA_WIDTH(tods_pkg::RESULT_WIDTH)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {{(tods_pkg::RSP_DATA_WIDTH - tods_pkg::RESULT_WIDTH){1'b0}}, rsp_result};

endmodule

[src/tods_checker.sv]
`timescale 1ns / 1ps
`include "time_of_day_clock_setter_assert.svh"
module tods_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic req_fire;
   logic req_stall;
   logic rsp_stall;
   logic rsp_fields_ok;

   assign req_fire  = req_tvalid && req_tready;
   assign req_stall = req_tvalid && !req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   assign rsp_fields_ok = rsp_tdata[4:0] <= tods_pkg::HOUR_MAX
                          && rsp_tdata[10:5] <= tods_pkg::MINSEC_MAX
                          && rsp_tdata[16:11] <= tods_pkg::MINSEC_MAX
                          && rsp_tdata[19:17] <= tods_pkg::STATUS_CALC
                          && rsp_tdata[23:20] == 4'd0;

   // stalled request beat holds
   `TODS_ASSERT_NEXT(a_req_hold, clock, reset, req_stall, req_tvalid && $stable({req_tdata, req_tuser}))

   // stalled result beat holds
   `TODS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // fields stay in range
   `TODS_ASSERT_NOW(a_rsp_range, clock, reset, rsp_tvalid, rsp_fields_ok)

   // empty output takes the result in the cycle after the request beat
   `TODS_ASSERT_NEXT(a_rsp_latency, clock, reset, req_fire && !rsp_tvalid, rsp_tvalid)

endmodule

bind time_of_day_clock_setter tods_checker u_tods_checker (.*);
